[rtl/core/i2cpe_pkg.sv]
// Shared types and constants for the I2C port expander master.
`timescale 1ns / 1ps

package i2cpe_pkg;

   localparam int AddrWidth = 7;
   localparam int DataWidth = 8;

   localparam logic [AddrWidth-1:0] ADDR_RESET = 7'h20;

   // transaction status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ADDR_NACK = 2'd1;
   localparam logic [1:0] ST_DATA_NACK = 2'd2;

   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 busy_res;
      logic                 done_res;
      logic [1:0]           status;
      logic [DataWidth-1:0] read_data;
   } rsp_type;

endpackage

[rtl/core/i2cpe_seq.sv]
// Bus sequencer: state registers and per-tick next-state logic.
`timescale 1ns / 1ps

module i2cpe_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [i2cpe_pkg::AddrWidth-1:0]     csr_data,
   input  logic                                step,
   input  logic                                req_request,
   input  logic                                req_opcode,
   input  logic [i2cpe_pkg::DataWidth-1:0]     req_write_data,
   input  logic                                req_sda_sample,
   output i2cpe_pkg::rsp_type                  rsp_c
);
   import i2cpe_pkg::*;

   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_START     = 4'd1;
   localparam logic [3:0] PH_SEND      = 4'd2;
   localparam logic [3:0] PH_SEND_TAIL = 4'd3;
   localparam logic [3:0] PH_ACK       = 4'd4;
   localparam logic [3:0] PH_RECV      = 4'd5;
   localparam logic [3:0] PH_RECV_TAIL = 4'd6;
   localparam logic [3:0] PH_NACK      = 4'd7;
   localparam logic [3:0] PH_STOP      = 4'd8;

   logic [AddrWidth-1:0] dev_addr_ff;
   logic [3:0]           phase_ff, phase_in;
   logic [1:0]           sub_ff, sub_in;
   logic [2:0]           bit_ff, bit_in;
   logic [DataWidth-1:0] shift_ff, shift_in;
   logic [DataWidth-1:0] latch_ff, latch_in;
   logic                 is_read_ff, is_read_in;
   logic [1:0]           stat_ff, stat_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 on_data_ff, on_data_in;
   rsp_type              res;

   always_comb begin
      phase_in   = phase_ff;
      sub_in     = sub_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      latch_in   = latch_ff;
      is_read_in = is_read_ff;
      stat_in    = stat_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      on_data_in = on_data_ff;
      res        = '0;

      if (phase_ff == PH_IDLE && req_request) begin
         is_read_in = req_opcode;
         latch_in   = req_write_data;
         shift_in   = {dev_addr_ff, req_opcode};
         stat_in    = ST_OK;
         on_data_in = 1'b0;
         bit_in     = '0;
         sub_in     = '0;
         phase_in   = PH_START;
      end

      res.busy_res = (phase_in != PH_IDLE);

      case (phase_in)
         PH_START: begin
            if (sub_in == 2'd0) begin
               scl_in = 1'b1;
               sda_in = 1'b1;
               sub_in = 2'd1;
            end else begin
               sda_in   = 1'b0;
               sub_in   = 2'd0;
               bit_in   = '0;
               phase_in = PH_SEND;
            end
         end
         PH_SEND: begin
            case (sub_in)
               2'd0: scl_in = 1'b0;
               2'd1: sda_in = shift_in[DataWidth-1];
               2'd2: scl_in = 1'b1;
               default: begin
                  scl_in   = 1'b0;
                  shift_in = {shift_in[DataWidth-2:0], 1'b0};
                  if (bit_in == 3'd7) begin
                     bit_in   = '0;
                     phase_in = PH_SEND_TAIL;
                  end else begin
                     bit_in = bit_in + 3'd1;
                  end
               end
            endcase
            sub_in = sub_in + 2'd1;
         end
         PH_SEND_TAIL: begin
            scl_in   = 1'b0;
            sub_in   = 2'd0;
            phase_in = PH_ACK;
         end
         PH_ACK: begin
            case (sub_in)
               2'd0: begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
               end
               2'd1: scl_in = 1'b1;
               2'd2: begin
                  scl_in = 1'b1;
                  if (req_sda_sample)
                     stat_in = on_data_in ? ST_DATA_NACK : ST_ADDR_NACK;
               end
               default: begin
                  scl_in = 1'b0;
                  if (stat_in != ST_OK || on_data_in) begin
                     phase_in = PH_STOP;
                  end else if (is_read_in) begin
                     shift_in = '0;
                     bit_in   = '0;
                     phase_in = PH_RECV;
                  end else begin
                     shift_in   = latch_in;
                     bit_in     = '0;
                     on_data_in = 1'b1;
                     phase_in   = PH_SEND;
                  end
               end
            endcase
            sub_in = sub_in + 2'd1;
         end
         PH_RECV: begin
            if (sub_in == 2'd0) begin
               scl_in = 1'b0;
               sda_in = 1'b1;
               sub_in = 2'd1;
            end else if (sub_in == 2'd1) begin
               scl_in = 1'b1;
               sub_in = 2'd2;
            end else begin
               scl_in   = 1'b1;
               shift_in = {shift_in[DataWidth-2:0], req_sda_sample};
               sub_in   = 2'd0;
               if (bit_in == 3'd7) begin
                  bit_in   = '0;
                  phase_in = PH_RECV_TAIL;
               end else begin
                  bit_in = bit_in + 3'd1;
               end
            end
         end
         PH_RECV_TAIL: begin
            scl_in   = 1'b0;
            sub_in   = 2'd0;
            phase_in = PH_NACK;
         end
         PH_NACK: begin
            case (sub_in)
               2'd0: scl_in = 1'b0;
               2'd1: sda_in = 1'b1;
               2'd2: scl_in = 1'b1;
               default: begin
                  scl_in   = 1'b0;
                  phase_in = PH_STOP;
               end
            endcase
            sub_in = sub_in + 2'd1;
         end
         PH_STOP: begin
            if (sub_in == 2'd0) begin
               scl_in = 1'b0;
               sda_in = 1'b0;
               sub_in = 2'd1;
            end else if (sub_in == 2'd1) begin
               scl_in = 1'b1;
               sub_in = 2'd2;
            end else begin
               sda_in       = 1'b1;
               res.done_res = 1'b1;
               res.status   = stat_in;
               res.read_data = (is_read_in && stat_in == ST_OK) ? shift_in : '0;
               sub_in       = 2'd0;
               phase_in     = PH_IDLE;
            end
         end
         default: begin
            // idle, or an unused code: release the bus
            scl_in   = 1'b1;
            sda_in   = 1'b1;
            phase_in = PH_IDLE;
         end
      endcase

      res.scl_level = scl_in;
      res.sda_level = sda_in;
   end

   assign rsp_c = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= ADDR_RESET;
      end else if (csr_write) begin
         dev_addr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         sub_ff     <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         latch_ff   <= '0;
         is_read_ff <= 1'b0;
         stat_ff    <= ST_OK;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         on_data_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         sub_ff     <= sub_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         latch_ff   <= latch_in;
         is_read_ff <= is_read_in;
         stat_ff    <= stat_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
         on_data_ff <= on_data_in;
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_c.done_res |-> rsp_c.busy_res)
      else $error("done without busy");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      !rsp_c.done_res |-> (rsp_c.status == ST_OK && rsp_c.read_data == '0))
      else $error("status or read data set off the final tick");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_STOP)
      else $error("phase code out of range");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_IDLE && !req_request) |=> phase_ff == PH_IDLE)
      else $error("left idle without a request");

   a_data_nack_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_c.done_res && rsp_c.status == ST_DATA_NACK) |-> !is_read_ff)
      else $error("data NACK reported on a read");

endmodule

[rtl/core/i2cpe_out.sv]
// Result register stage with valid/ready toward the consumer.
`timescale 1ns / 1ps

module i2cpe_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  i2cpe_pkg::rsp_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output i2cpe_pkg::rsp_type out_data
);
   import i2cpe_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   // a new item may enter whenever the held one is gone or leaves now
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

[rtl/core/i2c_port_expander_master_unit.sv]
// A result is on the rsp_ side in the cycle after its item is accepted.
// Throughput: one item per cycle; each item is one bus tick of the sequencer.
// The result register decouples the sides, so req_ready stays high while
// rsp_ready is high or no result is held.
// Reset (synchronous): sequencer idle, both bus lines released, address 0x20.
`timescale 1ns / 1ps

module i2c_port_expander_master_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [i2cpe_pkg::AddrWidth-1:0] csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_request,
   input  logic                            req_opcode,
   input  logic [i2cpe_pkg::DataWidth-1:0] req_write_data,
   input  logic                            req_sda_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_scl_level,
   output logic                            rsp_sda_level,
   output logic                            rsp_busy_res,
   output logic                            rsp_done_res,
   output logic [1:0]                      rsp_status,
   output logic [i2cpe_pkg::DataWidth-1:0] rsp_read_data
);
   import i2cpe_pkg::*;

   rsp_type seq_rsp;
   rsp_type out_rsp;
   logic    step;

   assign csr_ready = 1'b1;
   assign step      = req_valid && req_ready;

   i2cpe_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .step           (step),
      .req_request    (req_request),
      .req_opcode     (req_opcode),
      .req_write_data (req_write_data),
      .req_sda_sample (req_sda_sample),
      .rsp_c          (seq_rsp)
   );

   i2cpe_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (seq_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_rsp)
   );

   assign rsp_scl_level = out_rsp.scl_level;
   assign rsp_sda_level = out_rsp.sda_level;
   assign rsp_busy_res  = out_rsp.busy_res;
   assign rsp_done_res  = out_rsp.done_res;
   assign rsp_status    = out_rsp.status;
   assign rsp_read_data = out_rsp.read_data;

endmodule
